FILE: sv/mgtc_pkg.sv
// ----------------------------------------------------------------------------
// mgtc_pkg
// Codes and fixed-point constants shared by the gesture threshold calibrator.
// ----------------------------------------------------------------------------
package mgtc_pkg;

   localparam int DATA_W = 16;

   localparam logic [1:0] GEST_TAP    = 2'd0;
   localparam logic [1:0] GEST_STROKE = 2'd1;
   localparam logic [1:0] GEST_SHAKE  = 2'd2;
   localparam logic [1:0] GEST_LIFT   = 2'd3;

   localparam logic [2:0] RSN_OK         = 3'd0;
   localparam logic [2:0] RSN_TOO_SHORT  = 3'd1;
   localparam logic [2:0] RSN_WEAK_IMPACT = 3'd2;
   localparam logic [2:0] RSN_MOVING     = 3'd3;
   localparam logic [2:0] RSN_NO_TOUCH   = 3'd4;
   localparam logic [2:0] RSN_ROTATING   = 3'd5;
   localparam logic [2:0] RSN_SHAKE_WEAK = 3'd6;
   localparam logic [2:0] RSN_LIFT_WEAK  = 3'd7;

   // Percentile jobs: p10, p50 and p95 of linear acceleration, p95 of rate.
   localparam logic [1:0] JOB_LIN_P10  = 2'd0;
   localparam logic [1:0] JOB_LIN_P50  = 2'd1;
   localparam logic [1:0] JOB_LIN_P95  = 2'd2;
   localparam logic [1:0] JOB_RATE_P95 = 2'd3;

   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int          RECIP_SH  = 19;

   localparam logic [15:0] K_TAP_JERK_MIN   = 16'd90;
   localparam logic [15:0] K_BACKGROUND_MAX = 16'd51;
   localparam logic [8:0]  K_TAP_SCALE      = 9'd115;
   localparam logic [8:0]  K_BG_SCALE       = 9'd358;
   localparam logic [17:0] K_BG_OFFSET      = 18'd5;
   localparam logic [15:0] K_TOUCH_MIN      = 16'd5;
   localparam logic [15:0] K_STROKE_MID_MAX = 16'd90;
   localparam logic [15:0] K_ROTATE_MAX     = 16'd11520;
   localparam logic [8:0]  K_CONTACT_SCALE  = 9'd154;
   localparam logic [8:0]  K_GYRO_SCALE     = 9'd346;
   localparam logic [17:0] K_GYRO_OFFSET    = 18'd512;
   localparam logic [15:0] K_SHAKE_MIN      = 16'd51;
   localparam logic [8:0]  K_SHAKE_SCALE    = 9'd192;
   localparam logic [15:0] K_LIFT_MIN       = 16'd51;
   localparam logic [8:0]  K_LIFT_SCALE     = 9'd141;

   localparam logic [17:0] TAP_A_LO   = 18'd64;
   localparam logic [17:0] TAP_A_HI   = 18'd410;
   localparam logic [17:0] TAP_B_LO   = 18'd8;
   localparam logic [17:0] TAP_B_HI   = 18'd64;
   localparam logic [17:0] CONTACT_LO = 18'd4;
   localparam logic [17:0] CONTACT_HI = 18'd38;
   localparam logic [17:0] GYRO_LO    = 18'd2048;
   localparam logic [17:0] GYRO_HI    = 18'd10240;
   localparam logic [17:0] SHAKE_LO   = 18'd38;
   localparam logic [17:0] SHAKE_HI   = 18'd230;
   localparam logic [17:0] LIFT_LO    = 18'd38;
   localparam logic [17:0] LIFT_HI    = 18'd230;

   typedef logic [DATA_W-1:0] sample_type;

   function automatic logic [6:0] job_percent(input logic [1:0] job);
      logic [6:0] pct;
      unique case (job)
         JOB_LIN_P10:  pct = 7'd10;
         JOB_LIN_P50:  pct = 7'd50;
         JOB_LIN_P95:  pct = 7'd95;
         JOB_RATE_P95: pct = 7'd95;
         default:      pct = 7'd95;
      endcase
      return pct;
   endfunction

   function automatic logic [17:0] clamp18(input logic [17:0] v, input logic [17:0] lo,
                                           input logic [17:0] hi);
      logic [17:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: sv/mgtc_ram.sv
// ----------------------------------------------------------------------------
// mgtc_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mgtc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/motion_gesture_threshold_calibrator_top.sv
// ----------------------------------------------------------------------------
// motion_gesture_threshold_calibrator_top
// Collects motion samples into two sample memories, then derives gesture
// thresholds from peaks and percentiles found by radix selection.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Carries
//  req_      start / busy                one motion sample and its end flag
//  rsp_      rsp_strobe, one cycle       ok flag, reason and two thresholds
//  csr_      csr_valid / csr_ready       gesture target
//
// A sample is taken only while the block is not busy. A sample with the end
// flag starts an evaluation of four percentile selections over the samples
// past warm-up, each deciding one bit of the result per pass over the single
// read port of a sample memory; the evaluation and final states then produce
// the result. A recording that is too short skips the selections. Reset is
// synchronous and needs no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module motion_gesture_threshold_calibrator_top #(
   parameter int MAX_SAMPLES    = 512,
   parameter int WARMUP_SAMPLES = 60
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  mgtc_pkg::sample_type req_jerk_value,
   input  logic signed [15:0]   req_upward_accel,
   input  mgtc_pkg::sample_type req_linear_accel,
   input  mgtc_pkg::sample_type req_angular_rate,
   input  logic                 req_last_sample,
   output logic                 rsp_strobe,
   output logic                 rsp_calib_ok,
   output logic [2:0]           rsp_reason_code,
   output mgtc_pkg::sample_type rsp_threshold_a,
   output mgtc_pkg::sample_type rsp_threshold_b,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_gesture_target
);
   import mgtc_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int XW = CW + 7;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_RANK_MUL = 3'd1;
   localparam logic [2:0] ST_RANK_DIV = 3'd2;
   localparam logic [2:0] ST_RANK_FIX = 3'd3;
   localparam logic [2:0] ST_SCAN     = 3'd4;
   localparam logic [2:0] ST_EVAL     = 3'd5;
   localparam logic [2:0] ST_FINAL    = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    target_ff;
   logic [CW-1:0] count_ff, count_in;
   sample_type    peak_jerk_ff, peak_jerk_in;
   sample_type    peak_up_ff, peak_up_in;
   logic [1:0]    job_ff;
   logic [XW-1:0] x_ff;
   logic [CW-1:0] q_ff;
   logic [CW-1:0] rank_ff;
   sample_type    prefix_ff;
   logic [3:0]    bit_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] idx_ff;
   logic          issue_ff;
   logic          rd_vld_ff;
   logic          rd_last_ff;
   sample_type    pct_ff [4];
   logic [16:0]   prod_a_ff;
   logic [16:0]   prod_b_ff;
   logic          rsp_strobe_ff;
   logic          rsp_ok_ff;
   logic [2:0]    rsp_reason_ff;
   sample_type    rsp_a_ff;
   sample_type    rsp_b_ff;

   logic          accept;
   logic [CW-1:0] warm_c;
   logic [CW-1:0] n_post;
   logic          store_wr;
   logic [AW-1:0] ram_addr;
   sample_type    lin_rd, rate_rd, scan_rd;
   logic [16:0]   hi_shift;
   logic          match;
   logic [CW-1:0] cnt_total;
   sample_type    prefix_next;
   logic [CW-1:0] rank_next;
   logic [XW+12:0] recip_prod;
   logic [XW-1:0]  q_times_100;
   sample_type     op_a, op_b;
   logic [8:0]     k_a, k_b;
   logic [24:0]    mul_a, mul_b;
   logic           res_ok;
   logic [2:0]     res_reason;
   logic [17:0]    res_a, res_b;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign warm_c    = CW'(WARMUP_SAMPLES);
   assign n_post    = count_ff - warm_c;
   assign store_wr  = accept && (count_ff < CW'(MAX_SAMPLES));
   assign ram_addr  = (state_ff == ST_IDLE) ? count_ff[AW-1:0]
                                            : AW'(WARMUP_SAMPLES) + idx_ff[AW-1:0];

   mgtc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES)) u_linear_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .addr    (ram_addr),
      .wr_data (req_linear_accel),
      .rd_data (lin_rd)
   );

   mgtc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES)) u_rate_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .addr    (ram_addr),
      .wr_data (req_angular_rate),
      .rd_data (rate_rd)
   );

   always_comb begin
      peak_jerk_in = peak_jerk_ff;
      peak_up_in   = peak_up_ff;
      count_in     = count_ff;
      if (accept) begin
         if (req_jerk_value > peak_jerk_ff) begin
            peak_jerk_in = req_jerk_value;
         end
         if (!req_upward_accel[15] && ($unsigned(req_upward_accel) > peak_up_ff)) begin
            peak_up_in = $unsigned(req_upward_accel);
         end
         if (store_wr) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   // One radix step: count entries sharing the decided prefix with a zero here.
   assign scan_rd     = (job_ff == JOB_RATE_P95) ? rate_rd : lin_rd;
   assign hi_shift    = 17'h1FFFF << (bit_ff + 5'd1);
   assign match       = (((scan_rd ^ prefix_ff) & hi_shift[15:0]) == '0) && !scan_rd[bit_ff];
   assign cnt_total   = cnt_ff + CW'(match);
   always_comb begin
      prefix_next = prefix_ff;
      rank_next   = rank_ff;
      if (rank_ff >= cnt_total) begin
         prefix_next[bit_ff] = 1'b1;
         rank_next           = rank_ff - cnt_total;
      end
   end

   assign recip_prod  = x_ff * RECIP_100;
   assign q_times_100 = XW'(q_ff) * XW'(100);

   always_comb begin
      unique case (target_ff)
         GEST_TAP: begin
            op_a = peak_jerk_ff;
            k_a  = K_TAP_SCALE;
         end
         GEST_STROKE: begin
            op_a = pct_ff[JOB_LIN_P10];
            k_a  = K_CONTACT_SCALE;
         end
         GEST_SHAKE: begin
            op_a = pct_ff[JOB_LIN_P10];
            k_a  = K_SHAKE_SCALE;
         end
         default: begin
            op_a = peak_up_ff;
            k_a  = K_LIFT_SCALE;
         end
      endcase
      if (target_ff == GEST_TAP) begin
         op_b = pct_ff[JOB_LIN_P95];
         k_b  = K_BG_SCALE;
      end else begin
         op_b = pct_ff[JOB_RATE_P95];
         k_b  = K_GYRO_SCALE;
      end
   end
   assign mul_a = op_a * k_a;
   assign mul_b = op_b * k_b;

   always_comb begin
      res_ok     = 1'b0;
      res_reason = RSN_OK;
      res_a      = '0;
      res_b      = '0;
      if (count_ff <= warm_c) begin
         res_reason = RSN_TOO_SHORT;
      end else begin
         unique case (target_ff)
            GEST_TAP: begin
               if (peak_jerk_ff < K_TAP_JERK_MIN) begin
                  res_reason = RSN_WEAK_IMPACT;
               end else if (pct_ff[JOB_LIN_P50] > K_BACKGROUND_MAX) begin
                  res_reason = RSN_MOVING;
               end else begin
                  res_ok = 1'b1;
                  res_a  = clamp18({1'b0, prod_a_ff}, TAP_A_LO, TAP_A_HI);
                  res_b  = clamp18({1'b0, prod_b_ff} + K_BG_OFFSET, TAP_B_LO, TAP_B_HI);
               end
            end
            GEST_STROKE: begin
               if (pct_ff[JOB_LIN_P50] < K_TOUCH_MIN) begin
                  res_reason = RSN_NO_TOUCH;
               end else if (pct_ff[JOB_LIN_P50] > K_STROKE_MID_MAX) begin
                  res_reason = RSN_MOVING;
               end else if (pct_ff[JOB_RATE_P95] > K_ROTATE_MAX) begin
                  res_reason = RSN_ROTATING;
               end else begin
                  res_ok = 1'b1;
                  res_a  = clamp18({1'b0, prod_a_ff}, CONTACT_LO, CONTACT_HI);
                  res_b  = clamp18({1'b0, prod_b_ff} + K_GYRO_OFFSET, GYRO_LO, GYRO_HI);
               end
            end
            GEST_SHAKE: begin
               if (pct_ff[JOB_LIN_P10] < K_SHAKE_MIN) begin
                  res_reason = RSN_SHAKE_WEAK;
               end else begin
                  res_ok = 1'b1;
                  res_a  = clamp18({1'b0, prod_a_ff}, SHAKE_LO, SHAKE_HI);
               end
            end
            default: begin
               if (peak_up_ff < K_LIFT_MIN) begin
                  res_reason = RSN_LIFT_WEAK;
               end else begin
                  res_ok = 1'b1;
                  res_a  = clamp18({1'b0, prod_a_ff}, LIFT_LO, LIFT_HI);
               end
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_sample) begin
               state_in = (count_in <= warm_c) ? ST_EVAL : ST_RANK_MUL;
            end
         end
         ST_RANK_MUL: state_in = ST_RANK_DIV;
         ST_RANK_DIV: state_in = ST_RANK_FIX;
         ST_RANK_FIX: state_in = ST_SCAN;
         ST_SCAN: begin
            if (rd_vld_ff && rd_last_ff && (bit_ff == 4'd0)) begin
               state_in = (job_ff == JOB_RATE_P95) ? ST_EVAL : ST_RANK_MUL;
            end
         end
         ST_EVAL:  state_in = ST_FINAL;
         ST_FINAL: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         target_ff     <= GEST_TAP;
         count_ff      <= '0;
         peak_jerk_ff  <= '0;
         peak_up_ff    <= '0;
         job_ff        <= JOB_LIN_P10;
         issue_ff      <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            target_ff <= csr_gesture_target;
         end
         if (state_ff == ST_FINAL) begin
            count_ff      <= '0;
            peak_jerk_ff  <= '0;
            peak_up_ff    <= '0;
            rsp_strobe_ff <= 1'b1;
         end else begin
            count_ff     <= count_in;
            peak_jerk_ff <= peak_jerk_in;
            peak_up_ff   <= peak_up_in;
         end
         if (state_ff == ST_IDLE) begin
            job_ff <= JOB_LIN_P10;
         end
         rd_vld_ff  <= issue_ff;
         rd_last_ff <= issue_ff && (idx_ff == n_post - CW'(1));
         if (issue_ff && (idx_ff == n_post - CW'(1))) begin
            issue_ff <= 1'b0;
         end
         if (state_ff == ST_RANK_FIX) begin
            issue_ff <= 1'b1;
         end
         if ((state_ff == ST_SCAN) && rd_vld_ff && rd_last_ff) begin
            if (bit_ff != 4'd0) begin
               issue_ff <= 1'b1;
            end else if (job_ff != JOB_RATE_P95) begin
               job_ff <= job_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RANK_MUL) begin
         x_ff <= XW'(n_post) * XW'(job_percent(job_ff));
      end
      if (state_ff == ST_RANK_DIV) begin
         q_ff <= recip_prod[RECIP_SH +: CW];
      end
      if (state_ff == ST_RANK_FIX) begin
         rank_ff   <= (q_times_100 > x_ff) ? q_ff - CW'(1) : q_ff;
         prefix_ff <= '0;
         bit_ff    <= 4'd15;
         cnt_ff    <= '0;
         idx_ff    <= '0;
      end
      if (state_ff == ST_SCAN) begin
         if (issue_ff) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (rd_vld_ff) begin
            if (rd_last_ff) begin
               prefix_ff <= prefix_next;
               rank_ff   <= rank_next;
               cnt_ff    <= '0;
               idx_ff    <= '0;
               if (bit_ff != 4'd0) begin
                  bit_ff <= bit_ff - 4'd1;
               end else begin
                  pct_ff[job_ff] <= prefix_next;
               end
            end else begin
               cnt_ff <= cnt_total;
            end
         end
      end
      if (state_ff == ST_EVAL) begin
         prod_a_ff <= mul_a[24:8];
         prod_b_ff <= mul_b[24:8];
      end
      if (state_ff == ST_FINAL) begin
         rsp_ok_ff     <= res_ok;
         rsp_reason_ff <= res_reason;
         rsp_a_ff      <= res_a[15:0];
         rsp_b_ff      <= res_b[15:0];
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_calib_ok    = rsp_ok_ff;
   assign rsp_reason_code = rsp_reason_ff;
   assign rsp_threshold_a = rsp_a_ff;
   assign rsp_threshold_b = rsp_b_ff;
endmodule

FILE: sim/calib_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calib_checker
// Watches the sample, result and register channels of the gesture threshold
// calibrator, keeps its own copy of the recording state, predicts every
// calibration result and compares each one as it leaves the block.
// ----------------------------------------------------------------------------
module calib_checker #(
   parameter int MAX_SAMPLES    = 512,
   parameter int WARMUP_SAMPLES = 60
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [15:0]       req_jerk_value,
   input  logic signed [15:0] req_upward_accel,
   input  logic [15:0]       req_linear_accel,
   input  logic [15:0]       req_angular_rate,
   input  logic              req_last_sample,
   input  logic              rsp_strobe,
   input  logic              rsp_calib_ok,
   input  logic [2:0]        rsp_reason_code,
   input  logic [15:0]       rsp_threshold_a,
   input  logic [15:0]       rsp_threshold_b,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_gesture_target,
   output int                failures,
   output int                outstanding
);
   import mgtc_pkg::*;

   typedef struct packed {
      logic        ok;
      logic [2:0]  reason;
      logic [15:0] thr_a;
      logic [15:0] thr_b;
   } calib_result_type;

   logic [15:0]      linear_mem [MAX_SAMPLES];
   logic [15:0]      rate_mem [MAX_SAMPLES];
   int               held;
   logic [15:0]      jerk_peak;
   logic [15:0]      up_peak;
   logic [1:0]       gesture;
   calib_result_type pending_results [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      failures++;
   endtask

   function automatic int percentile(input bit use_rate, input int pct);
      int vals [$];
      int n;
      int rank;
      n = held - WARMUP_SAMPLES;
      for (int i = WARMUP_SAMPLES; i < held; i++) begin
         vals.push_back(use_rate ? rate_mem[i] : linear_mem[i]);
      end
      vals.sort();
      rank = (n * pct) / 100;
      if (rank >= n) begin
         rank = n - 1;
      end
      return vals[rank];
   endfunction

   function automatic int bound(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic calib_result_type evaluate_recording();
      calib_result_type r;
      int lo_lin;
      int mid_lin;
      int hi_rate;
      r = '0;
      if (held <= WARMUP_SAMPLES) begin
         r.reason = RSN_TOO_SHORT;
      end else begin
         case (gesture)
            GEST_TAP: begin
               if (jerk_peak < K_TAP_JERK_MIN) begin
                  r.reason = RSN_WEAK_IMPACT;
               end else if (percentile(0, 50) > K_BACKGROUND_MAX) begin
                  r.reason = RSN_MOVING;
               end else begin
                  r.ok    = 1'b1;
                  r.reason = RSN_OK;
                  r.thr_a = bound((jerk_peak * K_TAP_SCALE) >> 8, TAP_A_LO, TAP_A_HI);
                  r.thr_b = bound(((percentile(0, 95) * K_BG_SCALE) >> 8) + K_BG_OFFSET,
                                  TAP_B_LO, TAP_B_HI);
               end
            end
            GEST_STROKE: begin
               lo_lin  = percentile(0, 10);
               mid_lin = percentile(0, 50);
               hi_rate = percentile(1, 95);
               if (mid_lin < K_TOUCH_MIN) begin
                  r.reason = RSN_NO_TOUCH;
               end else if (mid_lin > K_STROKE_MID_MAX) begin
                  r.reason = RSN_MOVING;
               end else if (hi_rate > K_ROTATE_MAX) begin
                  r.reason = RSN_ROTATING;
               end else begin
                  r.ok    = 1'b1;
                  r.reason = RSN_OK;
                  r.thr_a = bound((lo_lin * K_CONTACT_SCALE) >> 8, CONTACT_LO, CONTACT_HI);
                  r.thr_b = bound(((hi_rate * K_GYRO_SCALE) >> 8) + K_GYRO_OFFSET,
                                  GYRO_LO, GYRO_HI);
               end
            end
            GEST_SHAKE: begin
               lo_lin = percentile(0, 10);
               if (lo_lin < K_SHAKE_MIN) begin
                  r.reason = RSN_SHAKE_WEAK;
               end else begin
                  r.ok    = 1'b1;
                  r.reason = RSN_OK;
                  r.thr_a = bound((lo_lin * K_SHAKE_SCALE) >> 8, SHAKE_LO, SHAKE_HI);
               end
            end
            default: begin
               if (up_peak < K_LIFT_MIN) begin
                  r.reason = RSN_LIFT_WEAK;
               end else begin
                  r.ok    = 1'b1;
                  r.reason = RSN_OK;
                  r.thr_a = bound((up_peak * K_LIFT_SCALE) >> 8, LIFT_LO, LIFT_HI);
               end
            end
         endcase
      end
      return r;
   endfunction

   initial begin
      failures = 0;
   end

   always @(posedge clock) begin
      calib_result_type want;
      if (reset) begin
         held      = 0;
         jerk_peak = '0;
         up_peak   = '0;
         gesture   = GEST_TAP;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            gesture = csr_gesture_target;
         end
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_calib_ok !== want.ok) begin
                  report_mismatch("calib_ok", rsp_calib_ok, want.ok);
               end
               if (rsp_reason_code !== want.reason) begin
                  report_mismatch("reason_code", rsp_reason_code, want.reason);
               end
               if (rsp_threshold_a !== want.thr_a) begin
                  report_mismatch("threshold_a", rsp_threshold_a, want.thr_a);
               end
               if (rsp_threshold_b !== want.thr_b) begin
                  report_mismatch("threshold_b", rsp_threshold_b, want.thr_b);
               end
            end
         end
         if (start && !busy) begin
            if (req_jerk_value > jerk_peak) begin
               jerk_peak = req_jerk_value;
            end
            if (!req_upward_accel[15] && req_upward_accel[15:0] > up_peak) begin
               up_peak = req_upward_accel[15:0];
            end
            if (held < MAX_SAMPLES) begin
               linear_mem[held] = req_linear_accel;
               rate_mem[held]   = req_angular_rate;
               held++;
            end
            if (req_last_sample) begin
               pending_results.push_back(evaluate_recording());
               held      = 0;
               jerk_peak = '0;
               up_peak   = '0;
            end
         end
      end
      outstanding <= pending_results.size();
   end

   final begin
      if (pending_results.size() != 0) begin
         $display("%0d expected results never arrived", pending_results.size());
      end
   end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives recordings of motion samples into the gesture threshold calibrator
// under all four gesture targets, with random gaps between transfers, and
// gives the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb;
   import mgtc_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [15:0]       req_jerk_value = '0;
   logic signed [15:0] req_upward_accel = '0;
   logic [15:0]       req_linear_accel = '0;
   logic [15:0]       req_angular_rate = '0;
   logic              req_last_sample = 1'b0;
   logic              rsp_strobe;
   logic              rsp_calib_ok;
   logic [2:0]        rsp_reason_code;
   logic [15:0]       rsp_threshold_a;
   logic [15:0]       rsp_threshold_b;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_gesture_target = GEST_TAP;
   int                failures;
   int                outstanding;
   int                samples_sent = 0;
   int                recordings = 0;
   bit                gaps_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   motion_gesture_threshold_calibrator_top dut (
      .clock, .reset, .start, .busy,
      .req_jerk_value, .req_upward_accel, .req_linear_accel, .req_angular_rate,
      .req_last_sample,
      .rsp_strobe, .rsp_calib_ok, .rsp_reason_code, .rsp_threshold_a, .rsp_threshold_b,
      .csr_valid, .csr_ready, .csr_gesture_target
   );

   calib_checker calib_chk (
      .clock, .reset, .start, .busy,
      .req_jerk_value, .req_upward_accel, .req_linear_accel, .req_angular_rate,
      .req_last_sample,
      .rsp_strobe, .rsp_calib_ok, .rsp_reason_code, .rsp_threshold_a, .rsp_threshold_b,
      .csr_valid, .csr_ready, .csr_gesture_target,
      .failures, .outstanding
   );

   task automatic send_sample(input logic [15:0] jerk, input logic [15:0] up,
                              input logic [15:0] lin, input logic [15:0] rate,
                              input logic last);
      if (gaps_on && samples_sent < 1300 && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_jerk_value   <= jerk;
      req_upward_accel <= up;
      req_linear_accel <= lin;
      req_angular_rate <= rate;
      req_last_sample  <= last;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      samples_sent++;
   endtask

   // The block is left to settle before the register is touched.
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_target(input logic [1:0] target);
      wait_quiet();
      csr_gesture_target <= target;
      csr_valid          <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_recording(input int len);
      int lin_base;
      int lin_spread;
      int rate_base;
      int rate_spread;
      int jerk_top;
      int up_top;
      logic [15:0] jerk;
      logic [15:0] up;
      logic [15:0] lin;
      logic [15:0] rate;
      lin_base    = $urandom_range(0, 110);
      lin_spread  = $urandom_range(0, 60);
      rate_base   = $urandom_range(0, 13000);
      rate_spread = $urandom_range(0, 3000);
      jerk_top    = $urandom_range(0, 1) ? 200 : 95;
      up_top      = $urandom_range(0, 1) ? 120 : 55;
      gaps_on     = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            jerk = $urandom();
            up   = $urandom();
            lin  = $urandom();
            rate = $urandom();
         end else begin
            jerk = $urandom_range(0, jerk_top);
            up   = $urandom_range(0, 2 * up_top) - up_top;
            lin  = lin_base + $urandom_range(0, lin_spread);
            rate = rate_base + $urandom_range(0, rate_spread);
         end
         send_sample(jerk, up, lin, rate, i == len - 1);
      end
      recordings++;
   endtask

   initial begin
      int len;
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_target(GEST_LIFT);
      send_sample(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_sample(16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b1);
      send_sample(16'h0001, 16'hFFFF, 16'h0001, 16'h0001, 1'b0);
      send_sample(16'h8000, 16'h0001, 16'h8000, 16'h8000, 1'b1);
      write_target(GEST_TAP);
      send_sample(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0);
      send_sample(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1);
      write_target(GEST_STROKE);
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      write_target(GEST_SHAKE);
      send_sample(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1);

      while (samples_sent < 1600 || recordings < 12) begin
         if (recordings < 8 || $urandom_range(0, 2) == 0) begin
            write_target(recordings < 8 ? recordings[1:0] : 2'($urandom_range(0, 3)));
         end
         pick = $urandom_range(0, 99);
         if (recordings == 0) begin
            len = 60;
         end else if (recordings == 1) begin
            len = 61;
         end else if (recordings == 2) begin
            len = 560;
         end else if (pick < 20) begin
            len = $urandom_range(1, 60);
         end else if (pick < 98) begin
            len = $urandom_range(61, 100);
         end else begin
            len = $urandom_range(500, 560);
         end
         send_recording(len);
      end

      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: filelist.f
sv/mgtc_pkg.sv
sv/mgtc_ram.sv
sv/motion_gesture_threshold_calibrator_top.sv
sim/calib_checker.sv
sim/tb.sv
